FILE: rtl/dotcq_pkg.sv
// dotcq_pkg: shared constants and types for the timer callout queue
// depends on nothing; used by dotcq_cell and the top level
package dotcq_pkg;

    localparam int ENTRIES = 16;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);
    localparam int TIME_W  = 48;
    localparam int PER_W   = 32;
    localparam int ID_W    = 4;
    localparam int STEP_W  = 16;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_AT     = 2'd1;
    localparam logic [1:0] MODE_AFTER  = 2'd2;
    localparam logic [1:0] MODE_CANCEL = 2'd3;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] deadline;
        logic [PER_W-1:0]  period;
        logic              pending;
    } t_entry;

    typedef struct packed {
        logic shift;
        logic load;
        logic mark;
    } t_ctl;

endpackage

FILE: rtl/dotcq_cell.sv
// dotcq_cell: one slot of the insertion-ordered entry chain
// depends on dotcq_pkg; takes its right neighbor on a shift, a new entry on a load
module dotcq_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dotcq_pkg::t_ctl               i_ctl,
    input  dotcq_pkg::t_entry             i_next,
    input  dotcq_pkg::t_entry             i_new,
    input  logic [dotcq_pkg::TIME_W-1:0]  i_time,
    output dotcq_pkg::t_entry             o_ent,
    output logic [dotcq_pkg::TIME_W-1:0]  o_dist,
    output logic                          o_due
);
    import dotcq_pkg::*;

    t_entry r_ent;

    assign o_ent  = r_ent;
    assign o_dist = i_time - r_ent.deadline;
    assign o_due  = ~o_dist[TIME_W-1];

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ent.id       <= i_new.id;
            r_ent.deadline <= i_new.deadline;
            r_ent.period   <= i_new.period;
        end else if (i_ctl.shift) begin
            r_ent.id       <= i_next.id;
            r_ent.deadline <= i_next.deadline;
            r_ent.period   <= i_next.period;
        end
        if (!i_rst_n) begin
            r_ent.pending <= 1'b0;
        end else if (i_ctl.load) begin
            r_ent.pending <= 1'b0;
        end else if (i_ctl.shift) begin
            r_ent.pending <= i_next.pending;
        end else if (i_ctl.mark) begin
            r_ent.pending <= o_due;
        end
    end

endmodule

FILE: rtl/deadline_ordered_timer_callout_queue.sv
// deadline_ordered_timer_callout_queue: top level, sequencer over a chain of entry cells
// depends on dotcq_pkg and dotcq_cell
//
// input channel (i_valid/o_ready) carries one beat per request: tick, schedule
// at an absolute deadline, schedule after a delay, or cancel. the entries sit
// in a chain of cells in insertion order; a removal closes the gap by shifting
// the cells behind it one place, a schedule appends at the tail.
// a tick first updates the time and marks the due entries, then fires them
// one at a time: each firing scans the chain one cell a cycle for the
// largest overdue distance.
// results leave on the output channel (o_valid/i_ready), one beat per firing,
// last_of_tick set on the final one; the output register lets the scan go on
// while a result waits, and the sequencer holds when a second result is ready.
// configuration (i_cfg_valid/o_cfg_ready) writes time_step, always ready.
// reset empties the queue, clears time to zero and sets time_step to 1.
module deadline_ordered_timer_callout_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [1:0]                    i_mode,
    input  logic [dotcq_pkg::ID_W-1:0]    i_entry_id,
    input  logic [dotcq_pkg::TIME_W-1:0]  i_when_time,
    input  logic [dotcq_pkg::PER_W-1:0]   i_repeat_period,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dotcq_pkg::ID_W-1:0]    o_fired_entry,
    output logic [dotcq_pkg::TIME_W-1:0]  o_fired_deadline,
    output logic [dotcq_pkg::TIME_W-1:0]  o_current_time,
    output logic                          o_last_of_tick,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dotcq_pkg::STEP_W-1:0]  i_cfg_time_step
);
    import dotcq_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MARK = 4'b0010,
        ST_SCAN = 4'b0100,
        ST_FIRE = 4'b1000
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic [TIME_W-1:0]   r_time;
    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    r_left;
    logic [IDX_W-1:0]    r_idx;
    logic [IDX_W-1:0]    r_best;
    logic [TIME_W-1:0]   r_bdist;
    logic                r_found;

    t_entry              cells   [ENTRIES];
    t_entry              nexts   [ENTRIES];
    logic [TIME_W-1:0]   dists   [ENTRIES];
    logic [ENTRIES-1:0]  dues;
    logic [ENTRIES-1:0]  pend;
    logic [ENTRIES-1:0]  valids;
    t_ctl                ctls    [ENTRIES];

    logic                accept;
    logic                id_ok;
    logic [IDX_W-1:0]    hit_idx;
    logic                hit;
    logic                rm_en;
    logic                ap_en;
    logic [IDX_W-1:0]    rm_idx;
    logic [CNT_W-1:0]    tail;
    t_entry              new_ent;
    t_entry              best_ent;
    logic                fire_go;
    logic                mark_en;
    logic                cand;

    assign o_ready     = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;
    assign id_ok       = (32'(i_entry_id) < ENTRIES);
    assign best_ent    = cells[r_best];
    assign fire_go     = (r_state == ST_FIRE) && (!o_valid || i_ready);
    assign mark_en     = (r_state == ST_MARK);

    always_comb begin
        hit_idx = '0;
        hit     = 1'b0;
        for (int i = 0; i < ENTRIES; i++) begin
            valids[i] = (CNT_W'(i) < r_cnt);
            pend[i]   = cells[i].pending;
            if (valids[i] && cells[i].id == i_entry_id) begin
                hit     = 1'b1;
                hit_idx = hit_idx | IDX_W'(i);
            end
        end
    end

    always_comb begin
        rm_en   = 1'b0;
        ap_en   = 1'b0;
        rm_idx  = hit_idx;
        new_ent = '0;
        if (accept && i_mode != MODE_TICK && id_ok) begin
            rm_en        = hit;
            ap_en        = (i_mode != MODE_CANCEL);
            new_ent.id   = i_entry_id;
            new_ent.period = i_repeat_period;
            new_ent.deadline = (i_mode == MODE_AT) ? i_when_time : r_time + i_when_time;
        end else if (fire_go) begin
            rm_en        = 1'b1;
            rm_idx       = r_best;
            ap_en        = (best_ent.period != '0);
            new_ent.id   = best_ent.id;
            new_ent.period = best_ent.period;
            new_ent.deadline = best_ent.deadline + TIME_W'(best_ent.period);
        end
        tail = r_cnt - CNT_W'(rm_en);
    end

    genvar g;
    generate
        for (g = 0; g < ENTRIES; g++) begin : g_cell
            if (g == ENTRIES - 1) begin : g_end
                assign nexts[g] = '0;
            end else begin : g_mid
                assign nexts[g] = cells[g+1];
            end
            assign ctls[g].shift = rm_en && (IDX_W'(g) >= rm_idx);
            assign ctls[g].load  = ap_en && (CNT_W'(g) == tail);
            assign ctls[g].mark  = mark_en && valids[g];
            dotcq_cell u_cell (
                .i_clk  (i_clk),
                .i_rst_n(i_rst_n),
                .i_ctl  (ctls[g]),
                .i_next (nexts[g]),
                .i_new  (new_ent),
                .i_time (r_time),
                .o_ent  (cells[g]),
                .o_dist (dists[g]),
                .o_due  (dues[g])
            );
        end
    endgenerate

    assign cand = cells[r_idx].pending && (!r_found || dists[r_idx] > r_bdist);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= STEP_W'(1);
            r_time  <= '0;
            r_cnt   <= '0;
            r_left  <= '0;
            r_idx   <= '0;
            r_found <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_step <= i_cfg_time_step;
            end
            r_cnt <= r_cnt + CNT_W'(ap_en) - CNT_W'(rm_en);
            if (o_valid && i_ready) begin
                o_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && i_mode == MODE_TICK) begin
                        r_time  <= r_time + TIME_W'(r_step);
                        r_state <= ST_MARK;
                    end
                end
                ST_MARK: begin
                    r_left  <= CNT_W'($countones(dues & valids));
                    r_idx   <= '0;
                    r_found <= 1'b0;
                    r_state <= ((dues & valids) == '0) ? ST_IDLE : ST_SCAN;
                end
                ST_SCAN: begin
                    if (cand) begin
                        r_found <= 1'b1;
                    end
                    r_idx <= r_idx + IDX_W'(1);
                    if (32'(r_idx) == ENTRIES - 1) begin
                        r_state <= ST_FIRE;
                    end
                end
                ST_FIRE: begin
                    if (fire_go) begin
                        o_valid <= 1'b1;
                        r_left  <= r_left - CNT_W'(1);
                        r_idx   <= '0;
                        r_found <= 1'b0;
                        r_state <= (r_left == CNT_W'(1)) ? ST_IDLE : ST_SCAN;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_SCAN && cand) begin
            r_best  <= r_idx;
            r_bdist <= dists[r_idx];
        end
        if (fire_go) begin
            o_fired_entry    <= best_ent.id;
            o_fired_deadline <= best_ent.deadline;
            o_current_time   <= r_time;
            o_last_of_tick   <= (r_left == CNT_W'(1));
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= ENTRIES)
        else $error("entry count beyond capacity");

    a_idle_no_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (pend == '0))
        else $error("pending entries left after tick");

    a_left_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_left != '0 && r_left <= r_cnt))
        else $error("firing count out of range");

    a_fire_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIRE) |-> r_found)
        else $error("fire without a selected entry");

endmodule

FILE: test/deadline_ordered_timer_callout_queue_chk.sv
// checker for the timer callout queue: watches request, result and config beats,
// predicts firings with its own model of the entry table and compares in order
// depends on dotcq_pkg
`timescale 1ns / 1ps
module deadline_ordered_timer_callout_queue_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic                          i_ready_in,
    input  logic [1:0]                    i_mode,
    input  logic [dotcq_pkg::ID_W-1:0]    i_entry_id,
    input  logic [dotcq_pkg::TIME_W-1:0]  i_when_time,
    input  logic [dotcq_pkg::PER_W-1:0]   i_repeat_period,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [dotcq_pkg::ID_W-1:0]    i_fired_entry,
    input  logic [dotcq_pkg::TIME_W-1:0]  i_fired_deadline,
    input  logic [dotcq_pkg::TIME_W-1:0]  i_current_time,
    input  logic                          i_last_of_tick,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_ready,
    input  logic [dotcq_pkg::STEP_W-1:0]  i_cfg_time_step,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_fired_total
);
    import dotcq_pkg::*;

    typedef struct packed {
        logic [ID_W-1:0]   entry;
        logic [TIME_W-1:0] deadline;
        logic [TIME_W-1:0] now;
        logic              last;
    } t_firing;

    t_firing           fire_q[$];
    logic [STEP_W-1:0] step;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] dl[ENTRIES];
    logic [PER_W-1:0]  per[ENTRIES];
    logic              queued[ENTRIES];
    int                rank[ENTRIES];
    int                count;

    assign o_pending = fire_q.size();

    function automatic void drop(int e);
        if (!queued[e]) return;
        for (int j = 0; j < ENTRIES; j++)
            if (queued[j] && rank[j] > rank[e]) rank[j]--;
        queued[e] = 1'b0;
        count--;
    endfunction

    function automatic void enqueue(int e, logic [TIME_W-1:0] d);
        drop(e);
        dl[e] = d;
        rank[e] = count;
        count++;
        queued[e] = 1'b1;
    endfunction

    function automatic bit earlier(int a, int b);
        logic [TIME_W-1:0] da, db;
        da = now - dl[a];
        db = now - dl[b];
        if (da != db) return da > db;
        return rank[a] < rank[b];
    endfunction

    function automatic void predict_beat(logic [1:0] m, int e, logic [TIME_W-1:0] w,
                                         logic [PER_W-1:0] p);
        int due[$];
        int k;
        t_firing f;
        if (m == MODE_CANCEL) begin
            drop(e);
            dl[e] = '0;
            per[e] = '0;
            return;
        end
        if (m != MODE_TICK) begin
            per[e] = p;
            enqueue(e, m == MODE_AT ? w : now + w);
            return;
        end
        now = now + step;
        for (int i = 0; i < ENTRIES; i++) begin
            if (queued[i] && !(logic'((now - dl[i]) >> (TIME_W - 1)))) begin
                k = due.size();
                due.push_back(i);
                while (k > 0 && earlier(i, due[k-1])) begin
                    due[k] = due[k-1];
                    k--;
                end
                due[k] = i;
            end
        end
        foreach (due[n]) begin
            f.entry = ID_W'(due[n]);
            f.deadline = dl[due[n]];
            f.now = now;
            f.last = (n == due.size() - 1);
            fire_q.push_back(f);
            if (per[due[n]] != 0) enqueue(due[n], dl[due[n]] + per[due[n]]);
            else begin
                drop(due[n]);
                dl[due[n]] = '0;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        t_firing want;
        if (!i_rst_n) begin
            step = STEP_W'(1);
            now = '0;
            count = 0;
            for (int i = 0; i < ENTRIES; i++) begin
                queued[i] = 1'b0;
                rank[i] = 0;
                dl[i] = '0;
                per[i] = '0;
            end
            fire_q.delete();
            o_fail_count <= 0;
            o_fired_total <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) step = i_cfg_time_step;
            if (i_out_valid && i_out_ready) begin
                o_fired_total <= o_fired_total + 1;
                if (fire_q.size() == 0) begin
                    $display("%0t unexpected firing entry %0d", $time, i_fired_entry);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = fire_q.pop_front();
                    if (want != {i_fired_entry, i_fired_deadline, i_current_time,
                                 i_last_of_tick}) begin
                        $display("%0t mismatch exp entry %0d dl %h now %h last %b",
                                 $time, want.entry, want.deadline, want.now, want.last);
                        $display("%0t          got entry %0d dl %h now %h last %b",
                                 $time, i_fired_entry, i_fired_deadline,
                                 i_current_time, i_last_of_tick);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
            if (i_valid && i_ready_in)
                predict_beat(i_mode, int'(i_entry_id), i_when_time, i_repeat_period);
        end
    end

endmodule

FILE: test/deadline_ordered_timer_callout_queue_tb.sv
// testbench top for the timer callout queue: drives requests, config and result
// back-pressure; depends on dotcq_pkg, the block and deadline_ordered_timer_callout_queue_chk
// the checker predicts and compares, this module gives the verdict
`timescale 1ns / 1ps
module deadline_ordered_timer_callout_queue_tb;
    import dotcq_pkg::*;

    localparam longint LIMIT = 1500000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_valid = 1'b0;
    logic              o_ready;
    logic [1:0]        i_mode = MODE_TICK;
    logic [ID_W-1:0]   i_entry_id = '0;
    logic [TIME_W-1:0] i_when_time = '0;
    logic [PER_W-1:0]  i_repeat_period = '0;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic [ID_W-1:0]   o_fired_entry;
    logic [TIME_W-1:0] o_fired_deadline;
    logic [TIME_W-1:0] o_current_time;
    logic              o_last_of_tick;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [STEP_W-1:0] i_cfg_time_step = '0;
    int                fail_count;
    int                pending;
    int                fired_total;
    int                beats;
    longint            cycles = 0;
    bit                calm = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    deadline_ordered_timer_callout_queue u_top (.*);

    deadline_ordered_timer_callout_queue_chk u_chk (
        .i_clk, .i_rst_n, .i_valid, .i_ready_in(o_ready), .i_mode, .i_entry_id,
        .i_when_time, .i_repeat_period, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_fired_entry(o_fired_entry), .i_fired_deadline(o_fired_deadline),
        .i_current_time(o_current_time), .i_last_of_tick(o_last_of_tick),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_time_step,
        .o_fail_count(fail_count), .o_pending(pending), .o_fired_total(fired_total)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // result back-pressure in random bursts
    initial begin
        int n;
        @(posedge i_clk iff i_rst_n);
        forever begin
            i_ready <= 1'b1;
            n = $urandom_range(1, 12);
            repeat (n) @(posedge i_clk);
            if (!calm && $urandom_range(0, 1)) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 8);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    // valid stays up between back-to-back beats; it drops only for a gap or a drain
    task automatic send(logic [1:0] m, logic [ID_W-1:0] e, logic [TIME_W-1:0] w,
                        logic [PER_W-1:0] p);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= m;
        i_entry_id <= e;
        i_when_time <= w;
        i_repeat_period <= p;
        @(posedge i_clk iff o_ready);
        beats++;
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk iff pending == 0);
        repeat (ENTRIES * (ENTRIES + 2) + 8) @(posedge i_clk);
    endtask

    task automatic set_step(logic [STEP_W-1:0] s);
        i_cfg_valid <= 1'b1;
        i_cfg_time_step <= s;
        @(posedge i_clk iff o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [TIME_W-1:0] rnd48();
        return TIME_W'({$urandom(), $urandom()});
    endfunction

    // small delays mostly, so entries actually come due
    task automatic rnd_beat(int steps);
        int r;
        logic [PER_W-1:0] p;
        r = $urandom_range(0, 99);
        p = ($urandom_range(0, 2) == 0) ? 0 :
            ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 4 * steps);
        if (r < 45) send(MODE_TICK, ID_W'($urandom()), rnd48(), $urandom());
        else if (r < 75) send(MODE_AFTER, ID_W'($urandom()),
                              TIME_W'($urandom_range(0, 6 * steps)), p);
        else if (r < 85) send(MODE_AFTER, ID_W'($urandom()), rnd48(), $urandom());
        else if (r < 93) send(MODE_AT, ID_W'($urandom()), rnd48(), p);
        else send(MODE_CANCEL, ID_W'($urandom()), rnd48(), $urandom());
    endtask

    initial begin
        logic [STEP_W-1:0] steps[4] = '{16'd1, 16'd65535, 16'd0, 16'd300};
        beats = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, ties, wrap, cancel of idle entry, zero step
        send(MODE_TICK, 0, 0, 0);
        send(MODE_AT, 0, '1, 0);
        send(MODE_AT, 15, 48'h0, 32'hFFFF_FFFF);
        send(MODE_AT, 3, 48'h1, 0);
        send(MODE_AT, 4, 48'h1, 1);
        send(MODE_AFTER, 7, 48'h800000000000, 0);
        send(MODE_AFTER, 8, 0, 2);
        send(MODE_CANCEL, 9, '1, '1);
        send(MODE_AT, 3, 48'h1, 0);
        send(MODE_TICK, 0, 0, 0);
        send(MODE_TICK, 0, 0, 0);
        send(MODE_CANCEL, 15, 0, 0);
        send(MODE_CANCEL, 0, 0, 0);
        drain();
        set_step(0);
        send(MODE_AFTER, 5, 0, 0);
        send(MODE_TICK, 0, 0, 0);
        drain();
        set_step(16'hFFFF);
        for (int i = 0; i < ENTRIES; i++)
            send(MODE_AFTER, ID_W'(i), 48'h10, i[0] ? 5 : 0);
        send(MODE_TICK, 0, 0, 0);
        send(MODE_TICK, 0, 0, 0);
        for (int i = 0; i < ENTRIES; i++) send(MODE_CANCEL, ID_W'(i), 0, 0);
        drain();

        foreach (steps[s]) begin
            set_step(steps[s]);
            for (int k = 0; k < 55; k++) rnd_beat(steps[s] == 0 ? 1 : int'(steps[s]));
            drain();
        end
        set_step(STEP_W'($urandom_range(1, 65535)));
        calm = 1'b1;
        for (int k = 0; k < 40; k++) rnd_beat(int'(i_cfg_time_step));
        drain();

        $display("covered %0d request beats and %0d firing beats over five step settings",
                 beats, fired_total);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
